@@ rtl/set_assoc_cache_tag_lookup_core_assert.svh @@
// Assertion macros shared by the checker.
// The enclosing scope must provide clk and rst_n.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_CORE_ASSERT_SVH

// same-cycle implication
`define SACTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SACTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sactl_pkg.sv @@
`timescale 1ns / 1ps
package sactl_pkg;

  localparam int SET_COUNT  = 64;
  localparam int NUM_WAYS   = 4;
  localparam int ADDR_WIDTH = 48;

  localparam int SET_BITS = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_BITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int NUM_PAIRS = (NUM_WAYS + 1) / 2;
  localparam int TAG_W    = ADDR_WIDTH;
  localparam int STAMP_W  = 64;
  localparam int CNT_W    = 32;

  localparam int POL_W = 1;
  localparam int OFF_W = 4;
  localparam int SIB_W = 3;
  localparam int WIU_W = 3;
  localparam int SH_W  = OFF_W + 1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 4;

  localparam int IN_W        = ((ADDR_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 1 + WAY_BITS + 1 + 2 * CNT_W;
  localparam int OUT_W       = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [POL_W-1:0] POL_LRU = 1'b0;
  localparam logic [POL_W-1:0] POL_FIFO = 1'b1;

  localparam logic [OFF_W-1:0] OFF_RST = 4'd6;
  localparam logic [SIB_W-1:0] SIB_RST = 3'd6;
  localparam logic [WIU_W-1:0] WIU_RST = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY   = 2'd0,
    REG_OFFSET   = 2'd1,
    REG_SET_BITS = 2'd2,
    REG_WAYS     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOKUP = 2'd1,
    ST_SELECT = 2'd2,
    ST_COMMIT = 2'd3
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] last_use;
    logic [STAMP_W-1:0] fill;
  } way_entry_t;

  typedef way_entry_t [NUM_WAYS-1:0] row_t;

  typedef struct packed {
    logic [POL_W-1:0]    policy;
    logic [NUM_WAYS-1:0] way_mask;
    logic [NUM_WAYS-1:0] valid;
    logic [TAG_W-1:0]    tag;
  } lk_ctl_t;

  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] way;
    logic                evicted;
  } lk_res_t;

endpackage

@@ rtl/sactl_dir_ram.sv @@
`timescale 1ns / 1ps
module sactl_dir_ram
  import sactl_pkg::*;
(
  input  logic                clk,
  input  logic                re,
  input  logic [SET_BITS-1:0] raddr,
  output row_t                rdata,
  input  logic                we,
  input  logic [SET_BITS-1:0] waddr,
  input  logic [NUM_WAYS-1:0] wmask,
  input  way_entry_t          wentry
);

  row_t mem [SET_COUNT];
  row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (wmask[w]) begin
          mem[waddr][w] <= wentry;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/sactl_victim.sv @@
`timescale 1ns / 1ps
module sactl_victim
  import sactl_pkg::*;
(
  input  logic    clk,
  input  lk_ctl_t ctl,
  input  row_t    row,
  output lk_res_t res
);

  // stage 1: tag compare, first free way, pairwise stamp minimum
  logic                 hit_r;
  logic [WAY_BITS-1:0]  hit_way_r;
  logic                 free_r;
  logic [WAY_BITS-1:0]  free_way_r;
  logic [NUM_PAIRS-1:0] pv_r;
  logic [STAMP_W-1:0]   ps_r [NUM_PAIRS];
  logic [WAY_BITS-1:0]  pw_r [NUM_PAIRS];

  logic                 hit_c;
  logic [WAY_BITS-1:0]  hit_way_c;
  logic                 free_c;
  logic [WAY_BITS-1:0]  free_way_c;
  logic [STAMP_W-1:0]   s_c  [NUM_WAYS];
  logic [NUM_PAIRS-1:0] pv_c;
  logic [STAMP_W-1:0]   ps_c [NUM_PAIRS];
  logic [WAY_BITS-1:0]  pw_c [NUM_PAIRS];

  always_comb begin
    hit_c      = 1'b0;
    hit_way_c  = '0;
    free_c     = 1'b0;
    free_way_c = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      s_c[w] = (ctl.policy == POL_FIFO) ? row[w].fill : row[w].last_use;
      if (ctl.way_mask[w] && ctl.valid[w] && (row[w].tag == ctl.tag)) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_BITS'(w);
      end
      if (ctl.way_mask[w] && !ctl.valid[w]) begin
        free_c     = 1'b1;
        free_way_c = WAY_BITS'(w);
      end
    end
    for (int p = 0; p < NUM_PAIRS; p++) begin
      pv_c[p] = ctl.way_mask[2*p];
      ps_c[p] = s_c[2*p];
      pw_c[p] = WAY_BITS'(2*p);
      if ((2*p + 1 < NUM_WAYS) && ctl.way_mask[(2*p+1) % NUM_WAYS] &&
          (s_c[(2*p+1) % NUM_WAYS] < s_c[2*p])) begin
        ps_c[p] = s_c[(2*p+1) % NUM_WAYS];
        pw_c[p] = WAY_BITS'(2*p + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r      <= hit_c;
    hit_way_r  <= hit_way_c;
    free_r     <= free_c;
    free_way_r <= free_way_c;
    pv_r       <= pv_c;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      ps_r[p] <= ps_c[p];
      pw_r[p] <= pw_c[p];
    end
  end

  // stage 2: minimum across pairs, final way choice
  logic [STAMP_W-1:0]  best_s_c;
  logic [WAY_BITS-1:0] best_w_c;
  lk_res_t             res_c;
  lk_res_t             res_r;

  always_comb begin
    best_s_c = ps_r[0];
    best_w_c = pw_r[0];
    for (int p = 1; p < NUM_PAIRS; p++) begin
      if (pv_r[p] && (ps_r[p] < best_s_c)) begin
        best_s_c = ps_r[p];
        best_w_c = pw_r[p];
      end
    end
    res_c.hit     = hit_r;
    res_c.evicted = !hit_r && !free_r;
    if (hit_r) begin
      res_c.way = hit_way_r;
    end else if (free_r) begin
      res_c.way = free_way_r;
    end else begin
      res_c.way = best_w_c;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_c;
  end

  assign res = res_r;

endmodule

@@ rtl/set_assoc_cache_tag_lookup_core.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Payload                                       Transaction
// in_      in   access_address                                tvalid & tready
// out_     out  hit, way_used, evicted_valid, hit/miss total  tvalid & tready
// cfg_     in   register index, write data                    valid & ready
//
// Each access passes through set read, tag compare, victim select and
// write-back; out_tvalid is registered at write-back. Accesses go
// through the set memory one at a time; the next one is taken in the cycle
// after write-back, so no new access is taken before the last is written back.
// Reset clears the line valid flops at once; no clearing pass.
// A result stalled on out_ holds write-back; a new access is still taken
// while the previous result waits.
module set_assoc_cache_tag_lookup_core
  import sactl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // access_address
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // hit, way_used, evicted_valid,
                                           // hit_total, miss_total, zero pad
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data
);

  state_t state_r, state_nxt;

  logic [POL_W-1:0] policy_r;
  logic [OFF_W-1:0] off_r;
  logic [SIB_W-1:0] sib_r;
  logic [WIU_W-1:0] wiu_r;

  logic [SET_COUNT-1:0][NUM_WAYS-1:0] valid_r;
  logic [STAMP_W-1:0]  clock_r;
  logic [CNT_W-1:0]    hit_cnt_r;
  logic [CNT_W-1:0]    miss_cnt_r;
  logic [SET_BITS-1:0] set_r;
  logic [TAG_W-1:0]    tag_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  logic accept;
  logic commit;
  logic ram_re;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_LRU;
      off_r    <= OFF_RST;
      sib_r    <= SIB_RST;
      wiu_r    <= WIU_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POLICY:   policy_r <= cfg_data[POL_W-1:0];
        REG_OFFSET:   off_r    <= cfg_data[OFF_W-1:0];
        REG_SET_BITS: sib_r    <= cfg_data[SIB_W-1:0];
        REG_WAYS:     wiu_r    <= cfg_data[WIU_W-1:0];
        default: ;
      endcase
    end
  end

  // address split
  logic [SIB_W-1:0]      eff_ib;
  logic [SH_W-1:0]       tag_sh;
  logic [ADDR_WIDTH-1:0] addr;
  logic [ADDR_WIDTH-1:0] set_full;
  logic [SET_BITS-1:0]   set_c;
  logic [TAG_W-1:0]      tag_c;
  logic [NUM_WAYS-1:0]   way_mask;
  int                    eff_ways;

  always_comb begin
    if (32'(sib_r) > 32'(SET_BITS)) begin
      eff_ib = SIB_W'(SET_BITS);
    end else begin
      eff_ib = sib_r;
    end
    addr     = in_tdata[ADDR_WIDTH-1:0];
    set_full = addr >> off_r;
    set_c    = set_full[SET_BITS-1:0] & ~({SET_BITS{1'b1}} << eff_ib);
    tag_sh   = SH_W'(off_r) + SH_W'(eff_ib);
    tag_c    = TAG_W'(addr >> tag_sh);
    if (wiu_r == '0) begin
      eff_ways = 1;
    end else if (32'(wiu_r) > NUM_WAYS) begin
      eff_ways = NUM_WAYS;
    end else begin
      eff_ways = 32'(wiu_r);
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      way_mask[w] = (w < eff_ways);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    ram_re    = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ram_re    = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_nxt = ST_SELECT;
      ST_SELECT: state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (!out_valid_r || out_tready) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r <= set_c;
      tag_r <= tag_c;
    end
  end

  // set memory and lookup
  row_t       rd_row;
  lk_ctl_t    lk_ctl;
  lk_res_t    lk_res;
  logic       ram_we;
  way_entry_t wentry;
  logic [NUM_WAYS-1:0] wmask;

  sactl_dir_ram u_ram (
    .clk    (clk),
    .re     (ram_re),
    .raddr  (set_c),
    .rdata  (rd_row),
    .we     (ram_we),
    .waddr  (set_r),
    .wmask  (wmask),
    .wentry (wentry)
  );

  assign lk_ctl.policy   = policy_r;
  assign lk_ctl.way_mask = way_mask;
  assign lk_ctl.valid    = valid_r[set_r];
  assign lk_ctl.tag      = tag_r;

  sactl_victim u_victim (
    .clk (clk),
    .ctl (lk_ctl),
    .row (rd_row),
    .res (lk_res)
  );

  // write-back
  logic [STAMP_W-1:0] clock_nxt;
  logic [CNT_W-1:0]   hit_cnt_nxt;
  logic [CNT_W-1:0]   miss_cnt_nxt;

  always_comb begin
    clock_nxt    = clock_r + STAMP_W'(1);
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (lk_res.hit) begin
      if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
    end else begin
      if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
    end
    wentry.tag      = tag_r;
    wentry.last_use = clock_nxt;
    wentry.fill     = lk_res.hit ? rd_row[lk_res.way].fill : clock_nxt;
    wmask           = '0;
    wmask[lk_res.way] = 1'b1;
    ram_we = commit && (!lk_res.hit || (policy_r == POL_LRU));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      clock_r    <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else if (commit) begin
      valid_r[set_r][lk_res.way] <= 1'b1;
      clock_r    <= clock_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= OUT_W'({miss_cnt_nxt, hit_cnt_nxt, lk_res.evicted,
                            lk_res.way, lk_res.hit});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/sactl_checker.sv @@
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_lookup_core_assert.svh"
module sactl_checker
  import sactl_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OUT_W-1:0]     out_tdata
);

  `SACTL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `SACTL_ASSERT_NOW(a_hit_no_evict, out_tvalid && out_tdata[0], !out_tdata[WAY_BITS+1], "hit reported an eviction")
  `SACTL_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "second access taken while one is in flight")
  `SACTL_ASSERT_NOW(a_result_from_access, $rose(out_tvalid), $past(!in_tready), "result without an access in flight")

endmodule

bind set_assoc_cache_tag_lookup_core sactl_checker u_sactl_checker (.*);

@@ tb/sv/set_assoc_cache_tag_lookup_core_tb.sv @@
`timescale 1ns / 1ps
module set_assoc_cache_tag_lookup_core_tb;
  import sactl_pkg::*;

  localparam int LINES       = SET_COUNT * NUM_WAYS;
  localparam int WAY_LSB     = 1;
  localparam int EVICT_LSB   = WAY_LSB + WAY_BITS;
  localparam int HITS_LSB    = EVICT_LSB + 1;
  localparam int MISSES_LSB  = HITS_LSB + CNT_W;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    logic                hit;
    logic [WAY_BITS-1:0] way;
    logic                evicted;
    logic [CNT_W-1:0]    hits;
    logic [CNT_W-1:0]    misses;
  } lookup_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_data = '0;

  // directory mirror
  logic               dir_valid [LINES];
  logic [TAG_W-1:0]   dir_tag   [LINES];
  logic [STAMP_W-1:0] dir_used  [LINES];
  logic [STAMP_W-1:0] dir_fill  [LINES];
  logic [STAMP_W-1:0] access_clock;
  logic [CNT_W-1:0]   hit_tally;
  logic [CNT_W-1:0]   miss_tally;
  logic [POL_W-1:0]   cur_policy;
  logic [OFF_W-1:0]   cur_offset;
  logic [SIB_W-1:0]   cur_set_bits;
  logic [WIU_W-1:0]   cur_ways;

  lookup_result_t pending_lookups[$];
  int errors = 0;
  int accesses = 0;
  int cfg_writes = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;

  set_assoc_cache_tag_lookup_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // access_address
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // hit, way_used, evicted_valid, hit_total, miss_total
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < LINES; i++) begin
      dir_valid[i] = 1'b0;
    end
    access_clock = '0;
    hit_tally    = '0;
    miss_tally   = '0;
    cur_policy   = POL_LRU;
    cur_offset   = OFF_RST;
    cur_set_bits = SIB_RST;
    cur_ways     = WIU_RST;
  end

  function automatic int index_bits_used();
    int b;
    b = int'(cur_set_bits);
    while (b > 0 && (1 << b) > SET_COUNT) b--;
    return b;
  endfunction

  function automatic int ways_used();
    if (cur_ways == 0) return 1;
    if (cur_ways > NUM_WAYS) return NUM_WAYS;
    return int'(cur_ways);
  endfunction

  function automatic lookup_result_t predict_lookup(input logic [ADDR_WIDTH-1:0] addr);
    lookup_result_t r;
    logic [63:0] a64, set_idx, tag, best, stamp;
    int ib, nw, base, way;
    logic hit, found;
    a64 = {{(64-ADDR_WIDTH){1'b0}}, addr};
    ib = index_bits_used();
    nw = ways_used();
    set_idx = (a64 >> cur_offset) & ((64'd1 << ib) - 64'd1);
    tag = a64 >> (cur_offset + ib);
    base = int'(set_idx) * NUM_WAYS;
    way = 0;
    hit = 1'b0;
    found = 1'b0;
    best = '0;
    access_clock = access_clock + 64'd1;
    for (int w = 0; w < nw; w++) begin
      if (!hit && dir_valid[base+w] && dir_tag[base+w] == tag[TAG_W-1:0]) begin
        hit = 1'b1;
        way = w;
      end
    end
    r.evicted = 1'b0;
    if (hit) begin
      if (hit_tally != '1) hit_tally++;
      if (cur_policy == POL_LRU) dir_used[base+way] = access_clock;
    end else begin
      if (miss_tally != '1) miss_tally++;
      for (int w = 0; w < nw; w++) begin
        if (!found && !dir_valid[base+w]) begin
          found = 1'b1;
          way = w;
        end
      end
      if (!found) begin
        for (int w = 0; w < nw; w++) begin
          stamp = (cur_policy == POL_FIFO) ? dir_fill[base+w] : dir_used[base+w];
          if (w == 0 || stamp < best) begin
            best = stamp;
            way = w;
          end
        end
        r.evicted = 1'b1;
      end
      dir_valid[base+way] = 1'b1;
      dir_tag[base+way]   = tag[TAG_W-1:0];
      dir_fill[base+way]  = access_clock;
      dir_used[base+way]  = access_clock;
    end
    r.hit    = hit;
    r.way    = way[WAY_BITS-1:0];
    r.hits   = hit_tally;
    r.misses = miss_tally;
    return r;
  endfunction

  function automatic logic [ADDR_WIDTH-1:0] make_addr(input logic [63:0] tag,
                                                      input logic [63:0] set_idx,
                                                      input logic [63:0] low);
    logic [63:0] a;
    int ib;
    ib = index_bits_used();
    a = (tag << (cur_offset + ib))
      | ((set_idx & ((64'd1 << ib) - 64'd1)) << cur_offset)
      | (low & ((64'd1 << cur_offset) - 64'd1));
    return a[ADDR_WIDTH-1:0];
  endfunction

  // receiver
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_lookups.size() == 0) begin
        $error("result transaction with no access outstanding");
        errors++;
      end else begin
        exp_r = pending_lookups.pop_front();
        if (out_tdata[0] !== exp_r.hit) begin
          $error("hit: expected %0d, got %0d", exp_r.hit, out_tdata[0]);
          errors++;
        end
        if (out_tdata[WAY_LSB +: WAY_BITS] !== exp_r.way) begin
          $error("way_used: expected %0d, got %0d", exp_r.way,
                 out_tdata[WAY_LSB +: WAY_BITS]);
          errors++;
        end
        if (out_tdata[EVICT_LSB] !== exp_r.evicted) begin
          $error("evicted_valid: expected %0d, got %0d", exp_r.evicted,
                 out_tdata[EVICT_LSB]);
          errors++;
        end
        if (out_tdata[HITS_LSB +: CNT_W] !== exp_r.hits) begin
          $error("hit_total: expected %0d, got %0d", exp_r.hits,
                 out_tdata[HITS_LSB +: CNT_W]);
          errors++;
        end
        if (out_tdata[MISSES_LSB +: CNT_W] !== exp_r.misses) begin
          $error("miss_total: expected %0d, got %0d", exp_r.misses,
                 out_tdata[MISSES_LSB +: CNT_W]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_access(input logic [ADDR_WIDTH-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_lookups.push_back(predict_lookup(addr));
    accesses++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_POLICY:   cur_policy   = value[POL_W-1:0];
      REG_OFFSET:   cur_offset   = value[OFF_W-1:0];
      REG_SET_BITS: cur_set_bits = value[SIB_W-1:0];
      REG_WAYS:     cur_ways     = value[WIU_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_config(input logic [POL_W-1:0] pol, input logic [OFF_W-1:0] off,
                              input logic [SIB_W-1:0] sib, input logic [WIU_W-1:0] ways);
    wait_idle();
    write_reg(REG_POLICY, CFG_DW'(pol));
    write_reg(REG_OFFSET, CFG_DW'(off));
    write_reg(REG_SET_BITS, CFG_DW'(sib));
    write_reg(REG_WAYS, CFG_DW'(ways));
    cfg_valid <= 1'b0;
  endtask

  // reset config: fill a set, hit, then LRU evictions
  task automatic test_fill_and_evict();
    send_idle_pct = 19;
    recv_idle_pct = 66;
    send_access('0);
    send_access('1);
    send_access(make_addr(1, 0, 0));
    send_access(make_addr(2, 0, 5));
    send_access(make_addr(3, 0, 63));
    send_access('0);
    send_access(make_addr(4, 0, 0));
    send_access(make_addr(1, 0, 0));
    send_access('1);
  endtask

  // FIFO: a hit does not save the oldest fill
  task automatic test_fifo_replacement();
    apply_config(POL_FIFO, 0, 2, 2);
    send_access(make_addr(5, 1, 0));
    send_access(make_addr(6, 1, 0));
    send_access(make_addr(5, 1, 0));
    send_access(make_addr(7, 1, 0));
    send_access(make_addr(6, 1, 0));
  endtask

  // out-of-range set bits and ways, largest offset; no flush across reconfig
  task automatic test_config_extremes();
    apply_config(POL_LRU, 15, 7, 0);
    send_access(make_addr(1, 3, 0));
    send_access(make_addr(2, 3, 64'h7fff));
    send_access('1);
    apply_config(POL_FIFO, 12, 0, 7);
    send_access(make_addr(9, 0, 0));
    send_access('1);
    send_access('0);
    apply_config(POL_LRU, OFF_RST, SIB_RST, WIU_RST);
    send_access('0);
  endtask

  task automatic test_random_traffic();
    logic [63:0] tag_pool [6];
    logic [63:0] set_base, r64;
    logic [POL_W-1:0] pol;
    logic [OFF_W-1:0] off;
    logic [SIB_W-1:0] sib;
    logic [WIU_W-1:0] ways;
    int set_span;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin pol = POL_LRU;  off = 0;  sib = 0; ways = 1; end
        1: begin pol = POL_FIFO; off = 15; sib = 7; ways = 7; end
        2: begin pol = POL_LRU;  off = 12; sib = 6; ways = 4; end
        default: begin
          pol  = POL_W'($urandom_range(1));
          off  = OFF_W'($urandom_range(15));
          sib  = SIB_W'($urandom_range(7));
          ways = WIU_W'($urandom_range(7));
        end
      endcase
      if (p >= 4 && $urandom_range(1)) begin
        off  = OFF_W'($urandom_range(15));
        sib  = SIB_W'($urandom_range(7));
        ways = WIU_W'($urandom_range(7));
      end
      apply_config(pol, off, sib, ways);
      case (p / 4)
        0: begin send_idle_pct = 19; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int i = 0; i < 6; i++) begin
        r64 = {$urandom, $urandom};
        tag_pool[i] = $urandom_range(1) ? 64'($urandom_range(15)) : r64;
      end
      set_span = int'($urandom_range(1, 4));
      set_base = 64'($urandom_range(SET_COUNT - 1));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r64 = {$urandom, $urandom};
        if ($urandom_range(99) < 12) begin
          send_access(r64[ADDR_WIDTH-1:0]);
        end else begin
          send_access(make_addr(tag_pool[$urandom_range(5)],
                                set_base + 64'($urandom_range(set_span - 1)), r64));
        end
        // hold off the sender until the block drains
        if (p == 0 && i == PHASE_ITEMS / 2) wait_idle();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_and_evict();
    test_fifo_replacement();
    test_config_extremes();
    test_random_traffic();
    wait_idle();
    $display("Checked %0d lookups (%0d hits, %0d misses) over %0d register writes,",
             results_seen, hit_tally, miss_tally, cfg_writes);
    $display("LRU and FIFO, clamped set/way counts, offsets 0..15, varied backpressure.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
